// ----- design/gri_pkg.sv -----
// Package with the request and response types, word map and reset presets of the register block.
package gri_pkg;

    localparam int BANK_WORDS = 2048;
    localparam int IDX_W      = 11;
    localparam int ADDR_W     = $clog2(BANK_WORDS);
    localparam int DATA_W     = 32;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic BANK_HUB  = 1'b0;
    localparam logic BANK_CORE = 1'b1;

    // Interrupt words, common to both banks.
    localparam logic [IDX_W-1:0] W_STS     = IDX_W'(20);
    localparam logic [IDX_W-1:0] W_SET     = IDX_W'(21);
    localparam logic [IDX_W-1:0] W_CLR     = IDX_W'(22);
    localparam logic [IDX_W-1:0] W_MSK     = IDX_W'(23);
    localparam logic [IDX_W-1:0] W_MSK_SET = IDX_W'(24);
    localparam logic [IDX_W-1:0] W_MSK_CLR = IDX_W'(25);

    // Hub bank words.
    localparam logic [IDX_W-1:0] HUB_CFG0       = IDX_W'(0);
    localparam logic [IDX_W-1:0] HUB_CFG1       = IDX_W'(1);
    localparam logic [IDX_W-1:0] HUB_IDENT0     = IDX_W'(2);
    localparam logic [IDX_W-1:0] HUB_IDENT1     = IDX_W'(3);
    localparam logic [IDX_W-1:0] HUB_IDENT2     = IDX_W'(4);
    localparam logic [IDX_W-1:0] HUB_IDENT3     = IDX_W'(5);
    localparam logic [IDX_W-1:0] HUB_MMUC_CTRL  = IDX_W'(1024);
    localparam logic [IDX_W-1:0] HUB_MMU_CTL    = IDX_W'(1152);
    localparam logic [IDX_W-1:0] HUB_DEBUG_INFO = IDX_W'(1166);

    // Core bank words.
    localparam logic [IDX_W-1:0] CORE_IDENT0    = IDX_W'(0);
    localparam logic [IDX_W-1:0] CORE_IDENT1    = IDX_W'(1);
    localparam logic [IDX_W-1:0] CORE_IDENT2    = IDX_W'(2);
    localparam logic [IDX_W-1:0] CORE_MISC      = IDX_W'(6);
    localparam logic [IDX_W-1:0] CORE_CACHE_CTL = IDX_W'(12);

    // Request bits that are dropped before a word is stored.
    localparam logic [DATA_W-1:0] MMUC_DROP  = 32'h0000_0006;
    localparam logic [DATA_W-1:0] MMU_DROP   = 32'h0000_0084;
    localparam logic [DATA_W-1:0] CACHE_DROP = 32'h0000_0101;

    typedef struct packed {
        logic              operation;
        logic              bank;
        logic [IDX_W-1:0]  word_index;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pending;
    } rsp_t;

    // Value of a word right after reset.
    function automatic logic [DATA_W-1:0] reset_word(input logic bank,
                                                     input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] val;
        val = '0;
        if (bank == BANK_HUB) begin
            case (idx)
                HUB_CFG0:       val = 32'h0000_000f;
                HUB_CFG1:       val = 32'h0000_0045;
                HUB_IDENT0:     val = 32'h4255_4856;
                HUB_IDENT1:     val = 32'h000e_1124;
                HUB_IDENT2:     val = 32'h0000_0100;
                HUB_IDENT3:     val = 32'h0000_0e00;
                HUB_DEBUG_INFO: val = 32'h0000_0550;
                default:        val = '0;
            endcase
        end else begin
            case (idx)
                CORE_IDENT0: val = 32'h0444_3356;
                CORE_IDENT1: val = 32'h8100_1422;
                CORE_IDENT2: val = 32'h4007_8121;
                CORE_MISC:   val = 32'h0000_0006;
                default:     val = '0;
            endcase
        end
        return val;
    endfunction

    // True when a write to this word goes into the word store. Interrupt words live in
    // flops, and identification words are read only.
    function automatic logic store_writable(input logic bank, input logic [IDX_W-1:0] idx);
        logic ok;
        ok = 1'b1;
        case (idx)
            W_STS, W_SET, W_CLR, W_MSK, W_MSK_SET, W_MSK_CLR: ok = 1'b0;
            default:                                          ok = 1'b1;
        endcase
        if (bank == BANK_HUB) begin
            case (idx)
                HUB_IDENT0, HUB_IDENT1, HUB_IDENT2, HUB_IDENT3, HUB_DEBUG_INFO: ok = 1'b0;
                default: ;
            endcase
        end else begin
            case (idx)
                CORE_IDENT0, CORE_IDENT1, CORE_IDENT2: ok = 1'b0;
                default: ;
            endcase
        end
        return ok;
    endfunction

    // Bits kept when a word is stored.
    function automatic logic [DATA_W-1:0] keep_mask(input logic bank,
                                                    input logic [IDX_W-1:0] idx);
        logic [DATA_W-1:0] m;
        m = '1;
        if (bank == BANK_HUB) begin
            case (idx)
                HUB_MMUC_CTRL: m = ~MMUC_DROP;
                HUB_MMU_CTL:   m = ~MMU_DROP;
                default:       m = '1;
            endcase
        end else begin
            case (idx)
                CORE_CACHE_CTL: m = ~CACHE_DROP;
                default:        m = '1;
            endcase
        end
        return m;
    endfunction

endpackage

// ----- design/gpu_register_block_irq_unit.sv -----
// Top level of the graphics-core register block with its hub and core word stores.
//
// Usage: a bus master sends one request per access on the req channel (req_valid,
// req_stall, req). A request reads or writes one 32-bit word of the hub or the core
// bank. Every request gives exactly one response on the rsp channel (rsp_valid,
// rsp_stall, rsp): the stored word for a read, zero for a write, and the level of the
// interrupt line after the access.
// The word stores have a registered read port, and the response then sits in an output
// register. No new request is taken while the store read of the last one is in flight.
// Reset: rst_n clears the interrupt status and mask flops at once; after it a sweep
// writes the reset presets into all 2048 words of both stores, one word of each bank a
// cycle, and req_stall stays high during the sweep.
// Stall: while the response waits with rsp_stall high, req_stall is high too, so no
// request is lost and the held response and interrupt level do not change.
module gpu_register_block_irq_unit
    import gri_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [IDX_W:0]    BANK_LIMIT = (IDX_W+1)'(BANK_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(BANK_WORDS - 1);

    // Reset sweep over the word stores.
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    // A request whose store read is in flight.
    logic              pend_reg, pend_next;
    logic              pend_mem_reg;
    logic              pend_bank_reg;
    logic [DATA_W-1:0] pend_val_reg;

    // Interrupt status and mask words of both banks.
    logic [DATA_W-1:0] hub_sts_reg, hub_sts_next;
    logic [DATA_W-1:0] hub_msk_reg, hub_msk_next;
    logic [DATA_W-1:0] core_sts_reg, core_sts_next;
    logic [DATA_W-1:0] core_msk_reg, core_msk_next;

    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    logic [DATA_W-1:0] hub_mem  [BANK_WORDS];
    logic [DATA_W-1:0] core_mem [BANK_WORDS];
    logic [DATA_W-1:0] hub_rdata_reg;
    logic [DATA_W-1:0] core_rdata_reg;

    logic              accept;
    logic              in_bank;
    logic              is_write;
    logic              is_read;
    logic [ADDR_W-1:0] addr;
    logic              rd_en;
    logic              irq_level;

    logic              hub_we, core_we;
    logic [ADDR_W-1:0] hub_waddr, core_waddr;
    logic [DATA_W-1:0] hub_wdata, core_wdata;
    logic [DATA_W-1:0] wr_word;
    logic              wr_store;

    logic              rd_mem;
    logic [DATA_W-1:0] rd_val;

    assign req_stall = clearing_reg || pend_reg || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign in_bank   = ({1'b0, req.word_index} < BANK_LIMIT);
    assign is_write  = (req.operation == OP_WRITE) && in_bank;
    assign is_read   = (req.operation == OP_READ) && in_bank;
    assign addr      = req.word_index[ADDR_W-1:0];
    assign rd_en     = accept && is_read;

    assign irq_level = |((hub_sts_reg & ~hub_msk_reg) | (core_sts_reg & ~core_msk_reg));

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Reset sweep counter.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Store write ports: the sweep writes presets, otherwise a plain word write.
    assign wr_word  = req.write_data & keep_mask(req.bank, req.word_index);
    assign wr_store = accept && is_write && store_writable(req.bank, req.word_index);

    always_comb
    begin
        if (clearing_reg)
        begin
            hub_we     = 1'b1;
            core_we    = 1'b1;
            hub_waddr  = clr_cnt_reg;
            core_waddr = clr_cnt_reg;
            hub_wdata  = reset_word(BANK_HUB, IDX_W'(clr_cnt_reg));
            core_wdata = reset_word(BANK_CORE, IDX_W'(clr_cnt_reg));
        end
        else
        begin
            hub_we     = wr_store && (req.bank == BANK_HUB);
            core_we    = wr_store && (req.bank == BANK_CORE);
            hub_waddr  = addr;
            core_waddr = addr;
            hub_wdata  = wr_word;
            core_wdata = wr_word;
        end
    end

    // Interrupt set and clear words update the status and mask flops.
    always_comb
    begin
        hub_sts_next  = hub_sts_reg;
        hub_msk_next  = hub_msk_reg;
        core_sts_next = core_sts_reg;
        core_msk_next = core_msk_reg;
        if (accept && is_write)
        begin
            if (req.bank == BANK_HUB)
            begin
                case (req.word_index)
                    W_SET:     hub_sts_next = hub_sts_reg | req.write_data;
                    W_CLR:     hub_sts_next = hub_sts_reg & ~req.write_data;
                    W_MSK_SET: hub_msk_next = hub_msk_reg | req.write_data;
                    W_MSK_CLR: hub_msk_next = hub_msk_reg & ~req.write_data;
                    default: ;
                endcase
            end
            else
            begin
                case (req.word_index)
                    W_SET:     core_sts_next = core_sts_reg | req.write_data;
                    W_CLR:     core_sts_next = core_sts_reg & ~req.write_data;
                    W_MSK_SET: core_msk_next = core_msk_reg | req.write_data;
                    W_MSK_CLR: core_msk_next = core_msk_reg & ~req.write_data;
                    default: ;
                endcase
            end
        end
    end

    // Read source: status and mask words come from flops, the rest from the store.
    always_comb
    begin
        rd_mem = 1'b0;
        rd_val = '0;
        if (is_read)
        begin
            case (req.word_index)
                W_STS:   rd_val = (req.bank == BANK_HUB) ? hub_sts_reg : core_sts_reg;
                W_MSK:   rd_val = (req.bank == BANK_HUB) ? hub_msk_reg : core_msk_reg;
                default: rd_mem = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        pend_next      = accept;
        rsp_valid_next = rsp_valid_reg;
        if (pend_reg)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            hub_sts_reg   <= '0;
            hub_msk_reg   <= '0;
            core_sts_reg  <= '0;
            core_msk_reg  <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            hub_sts_reg   <= hub_sts_next;
            hub_msk_reg   <= hub_msk_next;
            core_sts_reg  <= core_sts_next;
            core_msk_reg  <= core_msk_next;
        end
    end

    // Payload of the request in flight and of the response.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_mem_reg  <= rd_mem;
            pend_bank_reg <= req.bank;
            pend_val_reg  <= rd_val;
        end
        if (pend_reg)
        begin
            if (pend_mem_reg)
            begin
                rsp_reg.read_data <= (pend_bank_reg == BANK_HUB) ? hub_rdata_reg
                                                                 : core_rdata_reg;
            end
            else
            begin
                rsp_reg.read_data <= pend_val_reg;
            end
            rsp_reg.irq_pending <= irq_level;
        end
    end

    // Word stores with a registered read port.
    always_ff @(posedge clk)
    begin
        if (hub_we)
        begin
            hub_mem[hub_waddr] <= hub_wdata;
        end
        if (rd_en)
        begin
            hub_rdata_reg <= hub_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_we)
        begin
            core_mem[core_waddr] <= core_wdata;
        end
        if (rd_en)
        begin
            core_rdata_reg <= core_mem[addr];
        end
    end

    // The output register is always free when a store read lands.
    assert property (@(posedge clk) disable iff (!rst_n) !(pend_reg && rsp_valid_reg))
        else $error("store read landed while a response was still held");

    // A request in flight becomes a response in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |=> rsp_valid_reg)
        else $error("request in flight produced no response");

    // Nothing is in flight while the reset sweep runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!pend_reg && !rsp_valid_reg))
        else $error("request handled during the reset sweep");

    // A held response reports the current interrupt level.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.irq_pending == irq_level))
        else $error("held interrupt level differs from the status flops");

endmodule
